/* src/tsch_pkg.sv */
package tsch_pkg;

  // group geometry
  localparam int NUM_WEIGHTS = 16;
  localparam int IN_W        = 32;
  localparam int CODES_W     = 2 * NUM_WEIGHTS;
  localparam int EXT_W       = (CODES_W > IN_W) ? CODES_W : IN_W;
  localparam int CNT_W       = $clog2(NUM_WEIGHTS + 1);
  localparam int HASH_W      = 64;

  // fnv-1a 64 offset basis
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

  typedef logic [1:0] code_t;

  localparam code_t CODE_NEG  = 2'd0;
  localparam code_t CODE_ZERO = 2'd1;
  localparam code_t CODE_POS  = 2'd2;
  localparam code_t CODE_BAD  = 2'd3;

  // sideband that rides along the hash rounds
  typedef struct packed {
    logic               flipped;
    logic               bad_code;
    logic [CODES_W-1:0] canon;
  } side_t;

  // one fnv-1a round: xor the code in, multiply by the prime 0x100_0000_01b3
  // prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1, so shifts and adds only
  function automatic logic [HASH_W-1:0] fnv_round(logic [HASH_W-1:0] h, code_t c);
    logic [HASH_W-1:0] x;
    x = h ^ HASH_W'(c);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // any element carrying the invalid code
  function automatic logic has_code3(logic [EXT_W-1:0] v);
    logic any;
    any = 1'b0;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      any = any | (v[2*i +: 2] == CODE_BAD);
    end
    return any;
  endfunction

endpackage

/* src/tsch_fnv_round.sv */
module tsch_fnv_round (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  logic [tsch_pkg::HASH_W-1:0] hash_i,
  input  tsch_pkg::code_t            code_i,
  input  tsch_pkg::side_t            side_i,
  output logic                       vld_o,
  output logic [tsch_pkg::HASH_W-1:0] hash_o,
  output tsch_pkg::side_t            side_o
);
  import tsch_pkg::*;

  logic              vld_r;
  logic [HASH_W-1:0] hash_r;
  side_t             side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // payload only moves when a transaction is present
  always_ff @(posedge clk) begin
    if (vld_i) begin
      hash_r <= fnv_round(hash_i, code_i);
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign hash_o = hash_r;
  assign side_o = side_r;

endmodule

/* src/ternary_sign_canonical_hash_unit.sv */
// Ternary sign-canonical hash unit. Each transaction carries a group of 16
// ternary weights as 2-bit codes (code = weight + 1, code 3 is invalid and
// read as zero with out_bad_code raised). The unit negates every weight when
// negatives outnumber positives, or on a nonzero tie when the first nonzero
// weight is negative, and returns the canonical codes, the flip flag and a
// 64-bit FNV-1a hash of the 16 canonical codes (one byte each, element 0
// first) with the flip flag xored into bit 0. The pipeline takes a new
// transaction on every clock: busy is held low and start alone launches a
// transaction. Each result appears on the out_ ports for a single cycle,
// flagged by out_valid, and is never held back, since the receiver has no
// way to stall it. The pipeline is one decode stage, one sign-decision
// stage, sixteen hash stages (one FNV round each, the multiply by the
// prime built from shifts and adds) and an output register. Results leave
// in the order their transactions came in.
module ternary_sign_canonical_hash_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsch_pkg::IN_W-1:0]   in_weight_codes,
  output logic                        out_valid,
  output logic [tsch_pkg::IN_W-1:0]   out_canonical_codes,
  output logic                        out_flipped,
  output logic [tsch_pkg::HASH_W-1:0] out_pattern_hash,
  output logic                        out_bad_code
);
  import tsch_pkg::*;

  localparam int LATENCY = NUM_WEIGHTS + 3;

  // never stalls: every start is taken
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // stage 1: decode, clean invalid codes, count signs, find first nonzero
  // ---------------------------------------------------------------------
  logic [EXT_W-1:0]   win;
  logic [CODES_W-1:0] codes_nxt;
  logic [CNT_W-1:0]   npos_nxt;
  logic [CNT_W-1:0]   nneg_nxt;
  logic               fneg_nxt;
  logic               bad_nxt;

  logic               vld_s1_r;
  logic [CODES_W-1:0] codes_s1_r;
  logic [CNT_W-1:0]   npos_s1_r;
  logic [CNT_W-1:0]   nneg_s1_r;
  logic               fneg_s1_r;
  logic               bad_s1_r;

  // elements past the 32 input bits read as code 0
  assign win = EXT_W'(in_weight_codes);

  always_comb begin
    code_t c;
    logic  seen;
    codes_nxt = '0;
    npos_nxt  = '0;
    nneg_nxt  = '0;
    fneg_nxt  = 1'b0;
    seen      = 1'b0;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      c = win[2*i +: 2];
      if (c == CODE_BAD) begin
        c = CODE_ZERO;
      end
      codes_nxt[2*i +: 2] = c;
      npos_nxt = npos_nxt + CNT_W'(c == CODE_POS);
      nneg_nxt = nneg_nxt + CNT_W'(c == CODE_NEG);
      // first nonzero weight decides a tie
      if (c != CODE_ZERO && !seen) begin
        seen     = 1'b1;
        fneg_nxt = (c == CODE_NEG);
      end
    end
    bad_nxt = has_code3(win);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
    end else begin
      vld_s1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      codes_s1_r <= codes_nxt;
      npos_s1_r  <= npos_nxt;
      nneg_s1_r  <= nneg_nxt;
      fneg_s1_r  <= fneg_nxt;
      bad_s1_r   <= bad_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: sign decision and canonical pattern
  // ---------------------------------------------------------------------
  logic  flip_nxt;
  side_t side_nxt;
  logic  vld_s2_r;
  side_t side_s2_r;

  always_comb begin
    if (nneg_s1_r > npos_s1_r) begin
      flip_nxt = 1'b1;
    end else if (nneg_s1_r == npos_s1_r && nneg_s1_r != '0) begin
      flip_nxt = fneg_s1_r;
    end else begin
      flip_nxt = 1'b0;
    end
    side_nxt.flipped  = flip_nxt;
    side_nxt.bad_code = bad_s1_r;
    // negation swaps the -1 and +1 codes, zero stays put
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      side_nxt.canon[2*i +: 2] = flip_nxt ? (CODE_POS - codes_s1_r[2*i +: 2])
                                          : codes_s1_r[2*i +: 2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s2_r <= 1'b0;
    end else begin
      vld_s2_r <= vld_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_s1_r) begin
      side_s2_r <= side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // hash stages: one fnv round per element, element 0 first
  // ---------------------------------------------------------------------
  logic [NUM_WEIGHTS:0] vld_chain;
  logic [HASH_W-1:0]    hash_chain [NUM_WEIGHTS+1];
  side_t                side_chain [NUM_WEIGHTS+1];

  assign vld_chain[0]  = vld_s2_r;
  assign hash_chain[0] = FNV_BASIS;
  assign side_chain[0] = side_s2_r;

  for (genvar g = 0; g < NUM_WEIGHTS; g++) begin : g_round
    tsch_fnv_round u_round (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_chain[g]),
      .hash_i (hash_chain[g]),
      .code_i (side_chain[g].canon[2*g +: 2]),
      .side_i (side_chain[g]),
      .vld_o  (vld_chain[g+1]),
      .hash_o (hash_chain[g+1]),
      .side_o (side_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // output register: fold in the flip flag, trim the pattern to the port
  // ---------------------------------------------------------------------
  side_t             side_last;
  logic [EXT_W-1:0]  canon_ext;
  logic              out_vld_r;
  logic [IN_W-1:0]   out_canon_r;
  logic              out_flip_r;
  logic [HASH_W-1:0] out_hash_r;
  logic              out_bad_r;

  assign side_last = side_chain[NUM_WEIGHTS];
  assign canon_ext = EXT_W'(side_last.canon);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_chain[NUM_WEIGHTS];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_chain[NUM_WEIGHTS]) begin
      out_canon_r <= canon_ext[IN_W-1:0];
      out_flip_r  <= side_last.flipped;
      out_hash_r  <= hash_chain[NUM_WEIGHTS] ^ HASH_W'(side_last.flipped);
      out_bad_r   <= side_last.bad_code;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_canonical_codes = out_canon_r;
  assign out_flipped         = out_flip_r;
  assign out_pattern_hash    = out_hash_r;
  assign out_bad_code        = out_bad_r;

`ifndef SYNTHESIS
  // every started transaction comes out as a result
  a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("transaction lost in the pipeline");

  // no result without a transaction that started it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a started transaction");

  // invalid codes never reach the canonical pattern
  a_clean_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !has_code3(EXT_W'(out_canonical_codes)))
    else $error("invalid code in canonical pattern");
`endif

endmodule
